// ===== hw/rtl/sps_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sps_pkg
// Shared constants and types of the slotted page store.
// ----------------------------------------------------------------------------
package sps_pkg;

	localparam int unsigned DATA_BYTES_DEF = 1024;
	localparam int unsigned SLOT_BYTES_DEF = 4;
	localparam int unsigned MAX_SLOTS_DEF  = 256;

	typedef enum logic [2:0] {
		FN_INSERT = 3'd0,
		FN_WRITE  = 3'd1,
		FN_DELETE = 3'd2,
		FN_READ   = 3'd3,
		FN_FIRST  = 3'd4,
		FN_NEXT   = 3'd5,
		FN_QUERY  = 3'd6,
		FN_SPARE  = 3'd7
	} func_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_NONE = 2'd1,
		ST_BAD  = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_INS,
		S_DIR,
		S_CHK,
		S_PGRD,
		S_MOVE,
		S_FIX,
		S_DFIN,
		S_DONE
	} state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sps_page_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sps_page_mem
// Record byte memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sps_page_mem #(
	parameter int unsigned DATA_BYTES = 1024
) (
	input  wire logic                          clk,
	input  wire logic                          we,
	input  wire logic [$clog2(DATA_BYTES)-1:0] waddr,
	input  wire logic [7:0]                    wdata,
	input  wire logic [$clog2(DATA_BYTES)-1:0] raddr,
	output logic      [7:0]                    rdata
);
	logic [7:0] mem [DATA_BYTES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== hw/rtl/slotted_page_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// slotted_page_store
// Slotted record page with a slot directory memory and a byte page memory.
// Insert, first and next scan the directory entries, one entry per cycle.
// Delete may move the bytes that lie below the deleted record, then fixes
// the directory entries of the records that it moved.
// One item is worked at a time; a finished result waits in the output register.
// Reset clears the control registers only; neither memory is cleared.
// ----------------------------------------------------------------------------
module slotted_page_store #(
	parameter int unsigned DATA_BYTES = sps_pkg::DATA_BYTES_DEF,
	parameter int unsigned SLOT_BYTES = sps_pkg::SLOT_BYTES_DEF,
	parameter int unsigned MAX_SLOTS  = sps_pkg::MAX_SLOTS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic        [15:0] cfg_wdata,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic        [2:0]  func,
	input  wire logic        [7:0]  slot_no,
	input  wire logic        [10:0] rec_len,
	input  wire logic        [9:0]  byte_index,
	input  wire logic        [7:0]  data_byte,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic             [1:0]  status,
	output logic             [15:0] page_no,
	output logic             [7:0]  found_slot,
	output logic             [10:0] length_out,
	output logic             [7:0]  byte_out,
	output logic signed      [11:0] avail_space,
	output logic                    is_empty
);
	import sps_pkg::*;

	localparam int unsigned AW   = $clog2(DATA_BYTES);
	localparam int unsigned PW   = $clog2(DATA_BYTES + 1);
	localparam int unsigned SW   = $clog2(MAX_SLOTS);
	localparam int unsigned CNTW = $clog2(MAX_SLOTS + 1);
	localparam int unsigned XW   = (CNTW > 9) ? CNTW : 9;
	localparam int unsigned DW   = 1 + 2 * PW;

	state_t state_q, state_d;
	logic rv_q, rv_d;
	logic [CNTW-1:0] count_q, count_d, live_q, live_d;
	logic [PW-1:0] top_q, top_d, free_q, free_d;
	logic [15:0] page_id_q;
	logic out_valid_q, out_valid_d;

	logic [2:0] func_q, func_d;
	logic [7:0] sn_q, sn_d;
	logic [10:0] len_q, len_d;
	logic [9:0] idx_q, idx_d;
	logic [7:0] db_q, db_d;
	logic [XW-1:0] ptr_q, ptr_d, ridx_q, ridx_d, found_q, found_d;
	logic hit_q, hit_d, moved_q, moved_d;
	logic [PW-1:0] mv_q, mv_d, off_q, off_d, dlen_q, dlen_d;
	logic [AW-1:0] mva_q, mva_d;
	status_t res_st_q, res_st_d;
	logic [10:0] lout_q, lout_d;
	logic [7:0] bout_q, bout_d;

	status_t o_st_q;
	logic [7:0] o_found_q, o_bout_q;
	logic [10:0] o_lout_q;
	logic [11:0] o_avail_q;
	logic o_empty_q;

	logic [DW-1:0] dir_mem [MAX_SLOTS];
	logic [DW-1:0] dir_rdata, dir_wdata;
	logic [SW-1:0] dir_raddr, dir_waddr;
	logic dir_we;

	logic pg_we;
	logic [AW-1:0] pg_waddr, pg_raddr;
	logic [7:0] pg_wdata, pg_rdata;

	logic r_live;
	logic [PW-1:0] r_off, r_len, mvm1;
	logic [XW-1:0] count_x, sn_x, s_x;
	logic [31:0] len32, free32, rlen32, baddr32, maddr32, fix32, avail32;
	logic want;

	sps_page_mem #(
		.DATA_BYTES(DATA_BYTES)
	) u_page (
		.clk  (clk),
		.we   (pg_we),
		.waddr(pg_waddr),
		.wdata(pg_wdata),
		.raddr(pg_raddr),
		.rdata(pg_rdata)
	);

	always_ff @(posedge clk) begin
		if (dir_we) begin
			dir_mem[dir_waddr] <= dir_wdata;
		end
		dir_rdata <= dir_mem[dir_raddr];
	end

	assign r_live  = dir_rdata[DW-1];
	assign r_off   = dir_rdata[2*PW-1:PW];
	assign r_len   = dir_rdata[PW-1:0];
	assign count_x = XW'(count_q);
	assign sn_x    = XW'(sn_q);
	assign s_x     = hit_q ? found_q : count_x;
	assign len32   = 32'(len_q);
	assign free32  = 32'(free_q);
	assign rlen32  = 32'(r_len);
	assign baddr32 = 32'(r_off) + 32'(idx_q);
	assign maddr32 = 32'(mva_q) + 32'(dlen_q);
	assign fix32   = 32'(r_off) + 32'(dlen_q);
	assign avail32 = free32 - 32'(SLOT_BYTES);
	assign mvm1    = mv_q - PW'(1);
	assign want    = (func_q == FN_INSERT) ? !r_live : r_live;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d     = state_q;
		rv_d        = 1'b0;
		count_d     = count_q;
		live_d      = live_q;
		top_d       = top_q;
		free_d      = free_q;
		func_d      = func_q;
		sn_d        = sn_q;
		len_d       = len_q;
		idx_d       = idx_q;
		db_d        = db_q;
		ptr_d       = ptr_q;
		ridx_d      = ridx_q;
		found_d     = found_q;
		hit_d       = hit_q;
		moved_d     = moved_q;
		mv_d        = mv_q;
		off_d       = off_q;
		dlen_d      = dlen_q;
		mva_d       = mva_q;
		res_st_d    = res_st_q;
		lout_d      = lout_q;
		bout_d      = bout_q;
		out_valid_d = out_valid_q && out_stall;
		dir_we      = 1'b0;
		dir_waddr   = sn_x[SW-1:0];
		dir_wdata   = {1'b0, off_q, dlen_q};
		dir_raddr   = ptr_q[SW-1:0];
		pg_we       = 1'b0;
		pg_waddr    = baddr32[AW-1:0];
		pg_wdata    = db_q;
		pg_raddr    = baddr32[AW-1:0];

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					func_d   = func;
					sn_d     = slot_no;
					len_d    = rec_len;
					idx_d    = byte_index;
					db_d     = data_byte;
					hit_d    = 1'b0;
					res_st_d = ST_OK;
					found_d  = '0;
					lout_d   = '0;
					bout_d   = '0;
					ptr_d    = (func == FN_NEXT) ? XW'(slot_no) + XW'(1) : '0;
					unique case (func)
						FN_INSERT, FN_FIRST, FN_NEXT: state_d = S_SCAN;
						FN_WRITE, FN_DELETE, FN_READ: state_d = S_DIR;
						default:                      state_d = S_DONE;
					endcase
				end
			end
			S_SCAN: begin
				if (rv_q && want) begin
					hit_d   = 1'b1;
					found_d = ridx_q;
					state_d = (func_q == FN_INSERT) ? S_INS : S_DONE;
				end else if (ptr_q < count_x) begin
					dir_raddr = ptr_q[SW-1:0];
					ridx_d    = ptr_q;
					ptr_d     = ptr_q + XW'(1);
					rv_d      = 1'b1;
				end else if (!rv_q) begin
					if (func_q == FN_INSERT) begin
						state_d = S_INS;
					end else begin
						res_st_d = ST_NONE;
						state_d  = S_DONE;
					end
				end
			end
			S_INS: begin
				state_d = S_DONE;
				if (len32 > free32) begin
					res_st_d = ST_NONE;
					found_d  = '0;
				end else if (!hit_q && ((32'(count_q) >= 32'(MAX_SLOTS)) ||
						(len32 + 32'(SLOT_BYTES) > free32))) begin
					res_st_d = ST_NONE;
					found_d  = '0;
				end else begin
					found_d   = s_x;
					dir_we    = 1'b1;
					dir_waddr = s_x[SW-1:0];
					dir_wdata = {1'b1, top_q - PW'(len_q), PW'(len_q)};
					top_d     = top_q - PW'(len_q);
					live_d    = live_q + CNTW'(1);
					if (!hit_q) begin
						count_d = count_q + CNTW'(1);
						free_d  = free_q - PW'(len_q) - PW'(SLOT_BYTES);
					end else begin
						free_d  = free_q - PW'(len_q);
					end
				end
			end
			S_DIR: begin
				if (sn_x < count_x) begin
					dir_raddr = sn_x[SW-1:0];
					state_d   = S_CHK;
				end else begin
					res_st_d = ST_BAD;
					state_d  = S_DONE;
				end
			end
			S_CHK: begin
				state_d = S_DONE;
				if (!r_live) begin
					res_st_d = ST_BAD;
				end else begin
					unique case (func_q)
						FN_WRITE: begin
							if (32'(idx_q) >= rlen32) begin
								res_st_d = ST_BAD;
							end else begin
								pg_we = (baddr32 < 32'(DATA_BYTES));
							end
						end
						FN_READ: begin
							lout_d = rlen32[10:0];
							if (32'(idx_q) >= rlen32) begin
								res_st_d = ST_BAD;
							end else begin
								state_d = S_PGRD;
							end
						end
						default: begin
							off_d  = r_off;
							dlen_d = r_len;
							mv_d   = r_off;
							if ((r_len != '0) && (r_off >= top_q) &&
									(32'(r_off) + rlen32 <= 32'(DATA_BYTES))) begin
								moved_d = 1'b1;
								state_d = S_MOVE;
							end else begin
								moved_d = 1'b0;
								state_d = S_DFIN;
							end
						end
					endcase
				end
			end
			S_PGRD: begin
				bout_d  = pg_rdata;
				state_d = S_DONE;
			end
			S_MOVE: begin
				if (rv_q) begin
					pg_we    = 1'b1;
					pg_waddr = maddr32[AW-1:0];
					pg_wdata = pg_rdata;
				end
				if (mv_q > top_q) begin
					pg_raddr = mvm1[AW-1:0];
					mva_d    = mvm1[AW-1:0];
					mv_d     = mvm1;
					rv_d     = 1'b1;
				end else begin
					ptr_d   = '0;
					state_d = S_FIX;
				end
			end
			S_FIX: begin
				if (rv_q && r_live && (r_len != '0) && (r_off < off_q)) begin
					dir_we    = 1'b1;
					dir_waddr = ridx_q[SW-1:0];
					dir_wdata = {1'b1, fix32[PW-1:0], r_len};
				end
				if (ptr_q < count_x) begin
					dir_raddr = ptr_q[SW-1:0];
					ridx_d    = ptr_q;
					ptr_d     = ptr_q + XW'(1);
					rv_d      = 1'b1;
				end else begin
					state_d = S_DFIN;
				end
			end
			S_DFIN: begin
				dir_we    = 1'b1;
				dir_waddr = sn_x[SW-1:0];
				dir_wdata = {1'b0, off_q, dlen_q};
				live_d    = live_q - CNTW'(1);
				if (moved_q) begin
					top_d  = top_q + dlen_q;
					free_d = free_q + dlen_q;
				end
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_valid_d = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rv_q        <= 1'b0;
			count_q     <= '0;
			live_q      <= '0;
			top_q       <= PW'(DATA_BYTES);
			free_q      <= PW'(DATA_BYTES);
			page_id_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rv_q        <= rv_d;
			count_q     <= count_d;
			live_q      <= live_d;
			top_q       <= top_d;
			free_q      <= free_d;
			out_valid_q <= out_valid_d;
			if (cfg_we) begin
				page_id_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		func_q   <= func_d;
		sn_q     <= sn_d;
		len_q    <= len_d;
		idx_q    <= idx_d;
		db_q     <= db_d;
		ptr_q    <= ptr_d;
		ridx_q   <= ridx_d;
		found_q  <= found_d;
		hit_q    <= hit_d;
		moved_q  <= moved_d;
		mv_q     <= mv_d;
		off_q    <= off_d;
		dlen_q   <= dlen_d;
		mva_q    <= mva_d;
		res_st_q <= res_st_d;
		lout_q   <= lout_d;
		bout_q   <= bout_d;
		if (state_q == S_DONE && (!out_valid_q || !out_stall)) begin
			o_st_q    <= res_st_q;
			o_found_q <= found_q[7:0];
			o_lout_q  <= lout_q;
			o_bout_q  <= bout_q;
			o_avail_q <= avail32[11:0];
			o_empty_q <= (live_q == '0);
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = o_st_q;
	assign page_no     = page_id_q;
	assign found_slot  = o_found_q;
	assign length_out  = o_lout_q;
	assign byte_out    = o_bout_q;
	assign avail_space = o_avail_q;
	assign is_empty    = o_empty_q;
endmodule
`default_nettype wire
